/* src/sfet_pkg.sv */
// Package for the start/finish elapsed timer.
// Holds the transaction structs, status and operation codes and shared constants.
// No dependencies.
`default_nettype none

package sfet_pkg;

    // Default depth of the start timestamp ring.
    localparam int DEF_RING_DEPTH = 16;

    // Timestamp field widths.
    localparam int SECS_W   = 40;
    localparam int MILLIS_W = 10;
    localparam int RUNS_W   = 5;
    localparam int STATUS_W = 2;

    localparam logic [MILLIS_W-1:0] MS_PER_SEC = MILLIS_W'(1000);
    localparam logic [MILLIS_W-1:0] MAX_MILLIS = MILLIS_W'(999);

    // Operation codes.
    localparam logic OP_START  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RING_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_START  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EARLY     = 2'd3;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // One stored timestamp.
    typedef struct packed {
        logic [SECS_W-1:0]   secs;
        logic [MILLIS_W-1:0] millis;
    } t_stamp;

    // Input transaction.
    typedef struct packed {
        logic                operation;
        logic [SECS_W-1:0]   time_seconds;
        logic [MILLIS_W-1:0] time_millis;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        logic [SECS_W-1:0]   elapsed_seconds;
        logic [MILLIS_W-1:0] elapsed_millis;
        logic [RUNS_W-1:0]   runs_in_flight;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // Elapsed-time computation result.
    typedef struct packed {
        t_stamp elapsed;
        logic   early;
    } t_diff;

endpackage

`default_nettype wire

/* src/start_finish_elapsed_timer.sv */
// Top level of the start/finish elapsed timer.
// Depends on sfet_pkg, sfet_ring and sfet_diff.
//
// Usage:
//   A transaction is accepted at a rising edge where start is high and busy is
//   low. i_item.operation selects a start event (timestamp is pushed into the
//   ring) or a finish event (oldest start is popped and the elapsed time is
//   computed). Milliseconds above 999 are saturated to 999.
//   Every transaction gives exactly one result on o_result, marked by o_done
//   for a single cycle; the receiver cannot stall it.
//   The result is on the ports in the cycle after the execute cycle. A new
//   transaction is not accepted while one is executing. The ring is a
//   synchronous memory with a registered read; the read of the oldest start
//   is issued at the accepting edge and the update happens in the cycle after.
//   busy is high for that one execute cycle; a new transaction may be
//   accepted in the same cycle in which the previous result is shown.
//   Reset (synchronous, active low) empties the ring, zeroes the pointers and
//   the last elapsed time, and drops any transaction in progress. The ring
//   contents need no clearing.
`default_nettype none

module start_finish_elapsed_timer #(
    parameter int RING_DEPTH = sfet_pkg::DEF_RING_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  sfet_pkg::t_in_item   i_item,
    output logic                 o_done,
    output sfet_pkg::t_out_item  o_result
);
    import sfet_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);

    t_state           r_state, n_state;
    logic             r_op;
    t_stamp           r_stamp;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_stamp           r_last, n_last;
    t_out_item        r_result, n_result;
    logic             r_done, n_done;

    logic             accept;
    logic             ring_wr_en;
    t_stamp           in_stamp;
    t_stamp           ring_rd_data;
    t_diff            diff;
    logic [STATUS_W-1:0] status;

    assign accept = start && !busy;

    // Saturate the incoming milliseconds before they are stored or compared.
    assign in_stamp.secs   = i_item.time_seconds;
    assign in_stamp.millis = (i_item.time_millis > MAX_MILLIS) ? MAX_MILLIS
                                                               : i_item.time_millis;

    // Start timestamp storage.
    sfet_ring #(
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (r_stamp),
        .i_rd_en   (accept),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (ring_rd_data)
    );

    // Elapsed time against the oldest waiting start.
    sfet_diff u_diff (
        .i_start  (ring_rd_data),
        .i_finish (r_stamp),
        .o_diff   (diff)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        busy = 1'b0;
        case (r_state)
            S_IDLE:  busy = 1'b0;
            S_EXEC:  busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    // Read, modify and write back the ring bookkeeping in the execute cycle.
    always_comb begin
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_count    = r_count;
        n_last     = r_last;
        status     = ST_OK;
        ring_wr_en = 1'b0;
        n_done     = 1'b0;
        if (r_state == S_EXEC) begin
            n_done = 1'b1;
            if (r_op == OP_START) begin
                if (r_count == FULL_CNT) begin
                    status = ST_RING_FULL;
                end else begin
                    ring_wr_en = 1'b1;
                    n_wr_ptr   = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end else begin
                if (r_count == '0) begin
                    status = ST_NO_START;
                end else begin
                    n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
                    n_count  = r_count - 1'b1;
                    if (diff.early) begin
                        n_last = '0;
                        status = ST_EARLY;
                    end else begin
                        n_last = diff.elapsed;
                    end
                end
            end
        end
    end

    // Result transaction assembled from the updated state.
    always_comb begin
        n_result                 = r_result;
        if (r_state == S_EXEC) begin
            n_result.elapsed_seconds = n_last.secs;
            n_result.elapsed_millis  = n_last.millis;
            n_result.runs_in_flight  = RUNS_W'(n_count);
            n_result.status          = status;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_last   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_last   <= n_last;
            r_done   <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_item.operation;
            r_stamp <= in_stamp;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // A result is shown only right after an execute cycle.
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without a preceding execute cycle");

    // Every execute cycle produces a result.
    a_exec_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_done)
        else $error("execute cycle did not produce a result");

    // The fill count never passes the ring depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("ring fill count exceeds depth");

    // A dropped start reports a full ring.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_RING_FULL) |->
            (o_result.runs_in_flight == RUNS_W'(FULL_CNT)))
        else $error("start dropped while ring not full");

endmodule

`default_nettype wire

/* src/sfet_ring.sv */
// Start timestamp ring storage: one write port, one read port, registered read.
// Depends on sfet_pkg for the timestamp type.
`default_nettype none

module sfet_ring #(
    parameter int RING_DEPTH = sfet_pkg::DEF_RING_DEPTH,
    parameter int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  wire [PTR_W-1:0]      i_wr_addr,
    input  sfet_pkg::t_stamp     i_wr_data,
    input  wire                  i_rd_en,
    input  wire [PTR_W-1:0]      i_rd_addr,
    output sfet_pkg::t_stamp     o_rd_data
);
    import sfet_pkg::*;

    t_stamp r_mem [RING_DEPTH];
    t_stamp r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/sfet_diff.sv */
// Elapsed time between a start and a finish timestamp, with millisecond borrow.
// Depends on sfet_pkg for the timestamp and result types.
`default_nettype none

module sfet_diff (
    input  sfet_pkg::t_stamp i_start,
    input  sfet_pkg::t_stamp i_finish,
    output sfet_pkg::t_diff  o_diff
);
    import sfet_pkg::*;

    logic                borrow;
    logic                secs_lt;
    logic                secs_eq;
    logic [SECS_W-1:0]   secs_diff;
    logic [MILLIS_W-1:0] millis_diff;

    // Ordering of the two timestamps.
    assign secs_lt = i_finish.secs < i_start.secs;
    assign secs_eq = i_finish.secs == i_start.secs;
    assign borrow  = i_finish.millis < i_start.millis;

    // Seconds difference takes the millisecond borrow as a carry in.
    assign secs_diff = i_finish.secs - i_start.secs - SECS_W'(borrow);

    // Milliseconds wrap by one second when a borrow was taken.
    always_comb begin
        if (borrow) begin
            millis_diff = i_finish.millis + MS_PER_SEC - i_start.millis;
        end else begin
            millis_diff = i_finish.millis - i_start.millis;
        end
    end

    assign o_diff.early          = secs_lt || (secs_eq && borrow);
    assign o_diff.elapsed.secs   = secs_diff;
    assign o_diff.elapsed.millis = millis_diff;

endmodule

`default_nettype wire
